[hw/rtl/llkm_pkg.sv]
// Shared types, trie tables and lookup functions for the level keyword matcher.
package llkm_pkg;

    localparam int NODE_COUNT = 63;
    localparam int NODE_W     = 6;
    localparam int WORD_COUNT = 12;
    localparam int CHAR_W     = 8;
    localparam int LEVEL_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = ((STATUS_W + LEVEL_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z   = 8'h5A;

    localparam logic [NODE_W-1:0] ROOT_NODE = '0;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_LEVEL = 2'd1,
        ST_BAD_CHAR  = 2'd2
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic signed [LEVEL_W-1:0]  level;
    } llkm_result_t;

    localparam logic signed [LEVEL_W-1:0] LEVEL_NOT_LEVEL = -32'sd1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_BAD_CHAR  = -32'sd2;

    // Letter of node n sits at byte (NODE_COUNT - 1 - n) counted from the low end.
    localparam logic [8*(NODE_COUNT-1)-1:0] CHAIN_LETTERS =
        "ALLCRITICALDEBUGERRORFINESTINFONOTICEOFFSEVERETRACEVERBOSEWARN";

    localparam logic [NODE_W-1:0] WORD_FIRST [WORD_COUNT] = '{
        6'd1, 6'd4, 6'd12, 6'd17, 6'd22, 6'd28,
        6'd32, 6'd38, 6'd41, 6'd47, 6'd52, 6'd59
    };

    localparam logic [NODE_W-1:0] WORD_LAST [WORD_COUNT] = '{
        6'd3, 6'd11, 6'd16, 6'd21, 6'd27, 6'd31,
        6'd37, 6'd40, 6'd46, 6'd51, 6'd58, 6'd62
    };

    localparam logic signed [LEVEL_W-1:0] WORD_LEVEL [WORD_COUNT] = '{
        32'sh8000_0000, 32'sd90000, 32'sd30000, 32'sd70000,
        32'sd10000, 32'sd40000, 32'sd50000, 32'sh7FFF_FFFF,
        32'sd80000, 32'sd20000, 32'sd10000, 32'sd60000
    };

    function automatic logic [CHAR_W-1:0] node_letter(input logic [NODE_W-1:0] node);
        int pos;
        pos = NODE_COUNT - 1 - int'(node);
        if (node == ROOT_NODE) begin
            return CHAR_NUL;
        end
        return CHAIN_LETTERS[8*pos +: 8];
    endfunction

    function automatic logic is_word_end(input logic [NODE_W-1:0] node);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (WORD_LAST[i] == node) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] word_level(input logic [NODE_W-1:0] node);
        logic signed [LEVEL_W-1:0] lvl;
        lvl = LEVEL_NOT_LEVEL;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (WORD_LAST[i] == node) begin
                lvl = WORD_LEVEL[i];
            end
        end
        return lvl;
    endfunction

    // Child of the root for a letter, or the root itself when there is no edge.
    function automatic logic [NODE_W-1:0] root_child(input logic [CHAR_W-1:0] c);
        logic [NODE_W-1:0] nxt;
        nxt = ROOT_NODE;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (node_letter(WORD_FIRST[i]) == c) begin
                nxt = WORD_FIRST[i];
            end
        end
        return nxt;
    endfunction

endpackage

[hw/rtl/llkm_walker.sv]
// Trie walker: holds the match state and makes one transition per item.
module llkm_walker
    import llkm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                last_char,
    output llkm_result_t        result
);

    logic [NODE_W-1:0] node_reg, node_next;
    logic              dead_reg, dead_next;
    logic              bad_reg, bad_next;
    logic              ended_reg, ended_next;

    logic              live;
    logic              is_letter;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] node_inc;

    assign node_inc = node_reg + NODE_W'(1);

    always_comb begin
        live      = !ended_reg && !bad_reg && !dead_reg;
        is_letter = (char_code >= CHAR_A) && (char_code <= CHAR_Z);

        if (node_reg == ROOT_NODE) begin
            child = root_child(char_code);
        end else if ((node_reg >= NODE_W'(NODE_COUNT - 1)) || is_word_end(node_reg)) begin
            child = ROOT_NODE;
        end else if (node_letter(node_inc) == char_code) begin
            child = node_inc;
        end else begin
            child = ROOT_NODE;
        end

        node_next  = node_reg;
        dead_next  = dead_reg;
        bad_next   = bad_reg;
        ended_next = ended_reg;
        if (live) begin
            if (char_code == CHAR_NUL) begin
                ended_next = 1'b1;
            end else if (!is_letter) begin
                bad_next = 1'b1;
            end else if (child == ROOT_NODE) begin
                dead_next = 1'b1;
            end else begin
                node_next = child;
            end
        end

        if (bad_next) begin
            result.status = ST_BAD_CHAR;
            result.level  = LEVEL_BAD_CHAR;
        end else if (!dead_next && is_word_end(node_next)) begin
            result.status = ST_FOUND;
            result.level  = word_level(node_next);
        end else begin
            result.status = ST_NOT_LEVEL;
            result.level  = LEVEL_NOT_LEVEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg  <= ROOT_NODE;
            dead_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else if (step) begin
            if (last_char) begin
                node_reg  <= ROOT_NODE;
                dead_reg  <= 1'b0;
                bad_reg   <= 1'b0;
                ended_reg <= 1'b0;
            end else begin
                node_reg  <= node_next;
                dead_reg  <= dead_next;
                bad_reg   <= bad_next;
                ended_reg <= ended_next;
            end
        end
    end

endmodule

[hw/rtl/log_level_keyword_matcher_unit.sv]
// Top level of the level keyword matcher: input register, trie walker, result register.
// The block takes one byte of a level name per item and can accept an item in every
// cycle unless a held result item stalls the output; the last byte of a name passes from the
// input register through the single trie transition into the result register.
// Only an item with tlast produces a result item, carrying the match status and the
// level value.
module log_level_keyword_matcher_unit
    import llkm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [CHAR_W-1:0]       s_tdata,    // [7:0] char_code
    input  logic                    s_tlast,    // last_char
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata     // [1:0] match_status, [33:2] level_value
);

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    llkm_result_t        out_result_reg;
    llkm_result_t        result;
    logic                advance;
    logic                step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    llkm_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - STATUS_W - LEVEL_W){1'b0}},
                       out_result_reg.level, out_result_reg.status};

    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("Result item without a preceding last byte.");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("Input stalled while the pipeline could move.");

    a_bad_char_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_result_reg.status == ST_BAD_CHAR))
            |-> (out_result_reg.level == LEVEL_BAD_CHAR))
        else $error("Bad character result with wrong level value.");

endmodule
